// File: rtl/secp_pkg.sv
// Shared types, constants and the cosine table function for the servo enable sequencer.
package secp_pkg;

  localparam int COS_TABLE_DEPTH_DEF = 1024;
  localparam int COS_FRAC_BITS_DEF   = 16;

  localparam real HALF_PI = 6.28318530717958647692 / 4.0;

  // CiA 402 control words issued while the drive is brought up.
  localparam logic [15:0] CW_OFF       = 16'h0000;
  localparam logic [15:0] CW_SHUTDOWN  = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON = 16'h0007;
  localparam logic [15:0] CW_ENABLE    = 16'h000F;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_CYCLES   = 3'd0;
  localparam logic [2:0] CFG_MOTION_RANGE  = 3'd1;
  localparam logic [2:0] CFG_PERIOD_CYCLES = 3'd2;
  localparam logic [2:0] CFG_PHASE_STEP    = 3'd3;
  localparam logic [2:0] CFG_DRIVE_MODE    = 3'd4;

  // Register reset values.
  localparam logic [15:0]       STEP_CYCLES_RST   = 16'd1000;
  localparam logic [23:0]       MOTION_RANGE_RST  = 24'd30000;
  localparam logic [23:0]       PERIOD_CYCLES_RST = 24'd4000;
  localparam logic [31:0]       PHASE_STEP_RST    = 32'd1073742;
  localparam logic signed [7:0] DRIVE_MODE_RST    = 8'sd8;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_EN06   = 3'd1,
    PH_EN07   = 3'd2,
    PH_EN0F   = 3'd3,
    PH_MOTION = 3'd4
  } phase_t;

  // One quarter-wave entry: cosine of the angle scaled by 2^frac, rounded half up.
  function automatic longint cos_entry(real angle, int frac);
    real scaled;
    scaled = (2.0 ** frac) * $cos(angle);
    return longint'($floor(scaled + 0.5));
  endfunction

endpackage

// File: rtl/secp_ram.sv
// Generic single-port-write, registered-read RAM.
module secp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/servo_enable_and_cosine_profile.sv
// Servo enable sequencer with raised cosine position profile (top level).
// Path: an item transfers in to the input register, moves on to the output register and
// transfers out from there.
// Throughput: one item per cycle while m_tready does not stall the output; state, cosine ROM
// read and the profile multiply close each cycle. Reset (rst, synchronous): state and registers
// return to defaults, then the cosine ROM is loaded with its COS_TABLE_DEPTH+1 entries (1025 by
// default) with s_tready low; config writes are taken throughout.
module servo_enable_and_cosine_profile #(
  parameter int COS_TABLE_DEPTH = secp_pkg::COS_TABLE_DEPTH_DEF,
  parameter int COS_FRAC_BITS   = secp_pkg::COS_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // status_in[15:0], actual_pos[47:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // target_pos[31:0], control_out[47:32], mode_out[55:48],
                                 // phase_state[58:56], zero fill above
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import secp_pkg::*;

  localparam int AW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int FW = $clog2(COS_TABLE_DEPTH + 2);
  localparam int RW = COS_FRAC_BITS + 1;
  localparam int PW = RW + 26;

  // Configuration registers.
  logic [15:0]       step_cycles;
  logic [23:0]       motion_range;
  logic [23:0]       period_cycles;
  logic [31:0]       phase_step;
  logic signed [7:0] drive_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cycles   <= STEP_CYCLES_RST;
      motion_range  <= MOTION_RANGE_RST;
      period_cycles <= PERIOD_CYCLES_RST;
      phase_step    <= PHASE_STEP_RST;
      drive_mode    <= DRIVE_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_CYCLES:   step_cycles   <= cfg_data[15:0];
        CFG_MOTION_RANGE:  motion_range  <= cfg_data[23:0];
        CFG_PERIOD_CYCLES: period_cycles <= cfg_data[23:0];
        CFG_PHASE_STEP:    phase_step    <= cfg_data;
        CFG_DRIVE_MODE:    drive_mode    <= signed'(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // Quarter-wave cosine values, fixed at elaboration, copied into the ROM after reset.
  logic [RW-1:0] cos_tab [COS_TABLE_DEPTH+1];

  for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_cos
    localparam real ANGLE = HALF_PI * real'(g) / real'(COS_TABLE_DEPTH);
    assign cos_tab[g] = RW'(cos_entry(ANGLE, COS_FRAC_BITS));
  end

  logic [FW-1:0] fill_cnt;
  logic          fill_done;

  assign fill_done = (fill_cnt == FW'(COS_TABLE_DEPTH + 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (!fill_done) begin
      fill_cnt <= fill_cnt + FW'(1);
    end
  end

  // Handshake and pipeline registers.
  logic        s1_valid;
  logic [15:0] s1_status;
  logic [31:0] s1_pos;
  logic        out_ready;
  logic        s1_fire;

  assign out_ready = !m_tvalid || m_tready;
  assign s1_fire   = s1_valid && out_ready;
  assign s_tready  = fill_done && (!s1_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_status <= s_tdata[15:0];
      s1_pos    <= s_tdata[47:16];
    end
  end

  // Sequencer state.
  phase_t      ctrl_phase, ctrl_phase_next;
  logic [15:0] step_count, step_count_next;
  logic [31:0] base_position, base_position_next;
  logic [23:0] motion_count, motion_count_next;
  logic [31:0] phase_acc, phase_acc_next;

  logic [16:0] step_inc;
  logic [24:0] motion_inc;
  logic        step_end;
  logic        period_end;

  assign step_inc   = {1'b0, step_count} + 17'd1;
  assign motion_inc = {1'b0, motion_count} + 25'd1;
  assign step_end   = (step_inc >= {1'b0, step_cycles});
  assign period_end = (motion_inc >= {1'b0, period_cycles});

  always_comb begin
    ctrl_phase_next    = ctrl_phase;
    step_count_next    = step_count;
    base_position_next = base_position;
    motion_count_next  = motion_count;
    phase_acc_next     = phase_acc;
    if (s1_fire && (s1_status != 16'd0)) begin
      unique case (ctrl_phase)
        PH_WAIT: begin
          ctrl_phase_next = PH_EN06;
          step_count_next = '0;
        end
        PH_EN06, PH_EN07, PH_EN0F: begin
          step_count_next = step_inc[15:0];
          if (step_end) begin
            step_count_next = '0;
            unique case (ctrl_phase)
              PH_EN06: ctrl_phase_next = PH_EN07;
              PH_EN07: ctrl_phase_next = PH_EN0F;
              default: begin
                ctrl_phase_next    = PH_MOTION;
                base_position_next = s1_pos;
                motion_count_next  = '0;
                phase_acc_next     = '0;
              end
            endcase
          end
        end
        PH_MOTION: begin
          if (period_end) begin
            motion_count_next = '0;
            phase_acc_next    = '0;
          end else begin
            motion_count_next = motion_inc[23:0];
            phase_acc_next    = phase_acc + phase_step;
          end
        end
        default: begin
          ctrl_phase_next = PH_WAIT;
          step_count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_phase    <= PH_WAIT;
      step_count    <= '0;
      base_position <= '0;
      motion_count  <= '0;
      phase_acc     <= '0;
    end else begin
      ctrl_phase    <= ctrl_phase_next;
      step_count    <= step_count_next;
      base_position <= base_position_next;
      motion_count  <= motion_count_next;
      phase_acc     <= phase_acc_next;
    end
  end

  // The ROM is addressed from the phase the accumulator is about to hold, so its
  // registered output always matches the current phase_acc.
  logic [29+AW:0] idx_prod;
  logic [AW-1:0]  rom_idx;
  logic [AW-1:0]  rom_addr;
  logic [RW-1:0]  rom_data;

  assign idx_prod = (30+AW)'(phase_acc_next[29:0]) * (30+AW)'(COS_TABLE_DEPTH);
  assign rom_idx  = idx_prod[29+AW:30];
  assign rom_addr = phase_acc_next[30] ? (AW'(COS_TABLE_DEPTH) - rom_idx) : rom_idx;

  secp_ram #(
    .WIDTH(RW),
    .DEPTH(COS_TABLE_DEPTH + 1)
  ) u_cos_rom (
    .clk    (clk),
    .wr_en  (!fill_done),
    .wr_addr(fill_cnt[AW-1:0]),
    .wr_data(cos_tab[fill_cnt[AW-1:0]]),
    .rd_addr(rom_addr),
    .rd_data(rom_data)
  );

  // Raised cosine offset: (range * (1 - cos) + one) >> (F+1), half up.
  logic [RW:0]   one_q;
  logic [RW:0]   one_minus;
  logic [PW-1:0] prof_prod;
  logic [31:0]   offset;

  assign one_q     = (RW+1)'(1) << COS_FRAC_BITS;
  assign one_minus = (phase_acc[31] == phase_acc[30]) ? (one_q - (RW+1)'(rom_data))
                                                      : (one_q + (RW+1)'(rom_data));
  assign prof_prod = PW'(motion_range) * PW'(one_minus) + PW'(one_q);
  assign offset    = 32'(prof_prod >> RW);

  // Result of the item in the input register.
  logic [15:0] ctrl_word;
  logic [31:0] target;

  always_comb begin
    ctrl_word = CW_OFF;
    target    = s1_pos;
    if (s1_status != 16'd0) begin
      unique case (ctrl_phase)
        PH_WAIT, PH_EN06: ctrl_word = CW_SHUTDOWN;
        PH_EN07:          ctrl_word = CW_SWITCH_ON;
        PH_EN0F:          ctrl_word = CW_ENABLE;
        PH_MOTION: begin
          ctrl_word = CW_ENABLE;
          target    = base_position + offset;
        end
        default:          ctrl_word = CW_OFF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {5'd0, 3'(ctrl_phase_next), drive_mode, ctrl_word, target};
    end
  end

  // Checks.
  a_no_accept_during_fill: assert property (@(posedge clk) disable iff (rst)
    !fill_done |-> !s_tready)
    else $error("input accepted while the cosine ROM is loading");

  a_enable_word_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[47:32] == CW_ENABLE)) |->
      ((m_tdata[58:56] == 3'(PH_EN0F)) || (m_tdata[58:56] == 3'(PH_MOTION))))
    else $error("enable control word reported outside enable or motion phase");

  a_switch_on_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[47:32] == CW_SWITCH_ON)) |->
      ((m_tdata[58:56] == 3'(PH_EN07)) || (m_tdata[58:56] == 3'(PH_EN0F))))
    else $error("switch-on control word reported in the wrong phase");

  a_motion_start: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (ctrl_phase == PH_EN0F) && (ctrl_phase_next == PH_MOTION)) |=>
      ((phase_acc == 32'd0) && (motion_count == 24'd0) && (ctrl_phase == PH_MOTION)))
    else $error("motion did not start from phase zero");

endmodule
